// ----- rtl/core/plu_pkg.sv -----
// Shared types and constants of the polyline linear upsampler.
`default_nettype none
package plu_pkg;

  localparam int CFG_W = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STARTX,
    S_WAITX,
    S_STARTY,
    S_WAITY,
    S_EMIT,
    S_FINAL
  } plu_state_t;

  typedef struct packed {
    logic init;
    logic load_qr;
    logic step;
    logic neg;
  } plu_lane_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/plu_if.sv -----
// Point and vertex stream interfaces of the polyline linear upsampler.
`default_nettype none
interface plu_pt_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  logic                         series_end;

  modport source(output valid, pt_x, pt_y, series_end, input ready);
  modport sink(input valid, pt_x, pt_y, series_end, output ready);
endinterface

interface plu_vtx_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         run_last;
  logic                         strip_end;

  modport source(output valid, out_x, out_y, run_last, strip_end, input ready);
  modport sink(input valid, out_x, out_y, run_last, strip_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/plu_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module plu_divider #(
  parameter int CB = 24,
  parameter int KW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CB-1:0] dividend,
  input  wire logic [KW-1:0] divisor,
  output logic               done,
  output logic [CB-1:0]      quot,
  output logic [KW-1:0]      rem
);
  import plu_pkg::*;

  localparam int CW = $clog2(CB + 1);

  logic [CB-1:0] dvd_r;
  logic [KW:0]   rem_r;
  logic [KW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [KW:0]   rem_sh;
  logic          fits;

  assign rem_sh = {rem_r[KW-1:0], dvd_r[CB-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(CB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      dvd_r <= {dvd_r[CB-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r[KW-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/plu_lane.sv -----
// One coordinate lane: steps a value along a segment by quotient and remainder.
`default_nettype none
module plu_lane #(
  parameter int CB = 24,
  parameter int KW = 6
) (
  input  wire logic                  clk,
  input  wire plu_pkg::plu_lane_ctl_t ctl,
  input  wire logic [CB-1:0]         base,
  input  wire logic [CB-1:0]         quot,
  input  wire logic [KW-1:0]         rem,
  input  wire logic [KW-1:0]         den,
  output logic [CB-1:0]              value
);
  import plu_pkg::*;

  logic [CB-1:0] v_r;
  logic [CB-1:0] q_r;
  logic [KW-1:0] r_r;
  logic [KW-1:0] rr_r;
  logic          neg_r;
  logic [KW:0]   r_sum;
  logic          carry;
  logic [CB-1:0] inc;

  assign r_sum = {1'b0, r_r} + {1'b0, rr_r};
  assign carry = r_sum >= {1'b0, den};
  assign inc   = q_r + CB'(carry);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      v_r   <= base;
      r_r   <= den >> 1;
      neg_r <= ctl.neg;
    end else if (ctl.step) begin
      v_r <= neg_r ? (v_r - inc) : (v_r + inc);
      r_r <= carry ? KW'(r_sum - {1'b0, den}) : KW'(r_sum);
    end
    if (ctl.load_qr) begin
      q_r  <= quot;
      rr_r <= rem;
    end
  end

  assign value = v_r;

endmodule
`default_nettype wire

// ----- rtl/core/polyline_linear_upsampler_core.sv -----
// Top level of the polyline linear upsampler: sequencer, output register.
//
//   port     dir  protocol      payload
//   in_pt    in   valid/ready   pt_x, pt_y, series_end
//   out_vtx  out  valid/ready   out_x, out_y, run_last, strip_end
//   cfg_*    in   write enable  interp_count (6 bits)
//
// A point with no held predecessor starts no division. Otherwise one restoring
// divider serves x then y, followed by K + 1 emitted vertices, one more
// when the point ends its series. Reset is synchronous and clears the
// sequencer, configuration, held point and output valid. A stalled output
// holds the vertex register and pauses emission.
`default_nettype none
module polyline_linear_upsampler_core #(
  parameter int COORD_BITS = 24,
  parameter int MAX_INTERP = 62
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  plu_pt_if.sink                     in_pt,
  plu_vtx_if.source                  out_vtx,
  input  wire logic                  cfg_we,
  input  wire logic [plu_pkg::CFG_W-1:0] cfg_wdata
);
  import plu_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int KW = $clog2(MAX_INTERP + 2);

  plu_state_t    state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] den;
  logic [KW-1:0] j_r;
  logic [CB-1:0] prev_x_r, prev_y_r, nx_r, ny_r;
  logic          have_prev_r, last_r;
  logic          accept;
  logic          emit_go;
  logic [CB:0]   dx, dy;
  logic [CB-1:0] mag_x, mag_y;
  logic          div_start, div_done;
  logic [CB-1:0] div_quot;
  logic [KW-1:0] div_rem;
  plu_lane_ctl_t ctl_x, ctl_y;
  logic [CB-1:0] val_x, val_y;
  logic          out_valid_r, run_last_r, strip_end_r;
  logic [CB-1:0] out_x_r, out_y_r;

  assign k_eff = (cfg_r > CFG_W'(MAX_INTERP)) ? KW'(MAX_INTERP) : KW'(cfg_r);
  assign den   = k_eff + 1'b1;

  assign dx    = {nx_r[CB-1], nx_r} - {prev_x_r[CB-1], prev_x_r};
  assign dy    = {ny_r[CB-1], ny_r} - {prev_y_r[CB-1], prev_y_r};
  assign mag_x = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign mag_y = dy[CB] ? CB'(-dy) : dy[CB-1:0];

  assign in_pt.ready = (state_r == S_IDLE);
  assign accept      = in_pt.valid && in_pt.ready;
  assign emit_go     = (state_r == S_EMIT || state_r == S_FINAL) &&
                       (!out_valid_r || out_vtx.ready);

  plu_divider #(.CB(CB), .KW(KW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ((state_r == S_STARTY) ? mag_y : mag_x),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  plu_lane #(.CB(CB), .KW(KW)) u_lane_x (
    .clk   (clk),
    .ctl   (ctl_x),
    .base  (prev_x_r),
    .quot  (div_quot),
    .rem   (div_rem),
    .den   (den),
    .value (val_x)
  );

  plu_lane #(.CB(CB), .KW(KW)) u_lane_y (
    .clk   (clk),
    .ctl   (ctl_y),
    .base  (prev_y_r),
    .quot  (div_quot),
    .rem   (div_rem),
    .den   (den),
    .value (val_y)
  );

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    ctl_x     = '{init: 1'b0, load_qr: 1'b0, step: 1'b0, neg: dx[CB]};
    ctl_y     = '{init: 1'b0, load_qr: 1'b0, step: 1'b0, neg: dy[CB]};
    case (state_r)
      S_IDLE: begin
        if (accept && have_prev_r) state_nxt = S_STARTX;
      end
      S_STARTX: begin
        div_start  = 1'b1;
        ctl_x.init = 1'b1;
        ctl_y.init = 1'b1;
        state_nxt  = S_WAITX;
      end
      S_WAITX: begin
        if (div_done) begin
          ctl_x.load_qr = 1'b1;
          state_nxt     = S_STARTY;
        end
      end
      S_STARTY: begin
        div_start = 1'b1;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        if (div_done) begin
          ctl_y.load_qr = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          ctl_x.step = 1'b1;
          ctl_y.step = 1'b1;
          if (j_r == k_eff) state_nxt = last_r ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (emit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= '0;
      have_prev_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (accept && !have_prev_r && !in_pt.series_end) begin
        have_prev_r <= 1'b1;
        prev_x_r    <= in_pt.pt_x;
        prev_y_r    <= in_pt.pt_y;
      end
      if (state_r == S_STARTX) j_r <= '0;
      else if (state_r == S_EMIT && emit_go) j_r <= j_r + 1'b1;
      if (state_r == S_EMIT && emit_go && j_r == k_eff && !last_r) begin
        prev_x_r <= nx_r;
        prev_y_r <= ny_r;
      end
      if (state_r == S_FINAL && emit_go) begin
        have_prev_r <= 1'b0;
        prev_x_r    <= '0;
        prev_y_r    <= '0;
      end
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_vtx.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nx_r   <= in_pt.pt_x;
      ny_r   <= in_pt.pt_y;
      last_r <= in_pt.series_end;
    end
    if (emit_go) begin
      if (state_r == S_FINAL) begin
        out_x_r     <= nx_r;
        out_y_r     <= ny_r;
        run_last_r  <= 1'b1;
        strip_end_r <= 1'b1;
      end else begin
        out_x_r     <= val_x;
        out_y_r     <= val_y;
        run_last_r  <= (j_r == k_eff) && !last_r;
        strip_end_r <= 1'b0;
      end
    end
  end

  assign out_vtx.valid     = out_valid_r;
  assign out_vtx.out_x     = out_x_r;
  assign out_vtx.out_y     = out_y_r;
  assign out_vtx.run_last  = run_last_r;
  assign out_vtx.strip_end = strip_end_r;

  a_strip_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vtx.valid && out_vtx.strip_end |-> out_vtx.run_last)
    else $error("strip_end without run_last");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAITX || state_r == S_WAITY))
    else $error("divider finished outside a wait state");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> j_r <= k_eff)
    else $error("vertex index beyond count");

  a_held_point_divides: assert property (@(posedge clk) disable iff (!rst_n)
    accept && have_prev_r |=> state_r == S_STARTX)
    else $error("held point did not start division");

endmodule
`default_nettype wire
